/* src/bfc_pkg.sv */
package bfc_pkg;

  localparam int unsigned V_AW = 10;
  localparam int unsigned P_AW = 11;
  localparam int unsigned T_AW = 10;
  localparam int unsigned COORD_BITS = 12;

  localparam logic [2:0] OP_VERT = 3'd0;
  localparam logic [2:0] OP_PAIR = 3'd1;
  localparam logic [2:0] OP_TRI  = 3'd2;
  localparam logic [2:0] OP_RUN  = 3'd3;
  localparam logic [2:0] OP_READ = 3'd4;

  localparam logic [1:0] KIND_VERT = 2'd0;
  localparam logic [1:0] KIND_PAIR = 2'd1;
  localparam logic [1:0] KIND_TRI  = 2'd2;
  localparam logic [1:0] KIND_SUM  = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR,
    S_T_RD, S_T_E, S_T_PA, S_T_PB, S_T_V, S_T_M1, S_T_M2, S_T_CMP, S_T_W,
    S_P_RD, S_P_WR, S_N_RD, S_N_F, S_N_S, S_V_RD, S_V_WR, S_SUM,
    S_R_L, S_R_S, S_R_D, S_R_N, S_R_W, S_R_OUT
  } state_e;

  function automatic logic [11:0] edge_sel(input logic [35:0] w, input logic [1:0] k);
    logic [11:0] r;
    case (k)
      2'd0: r = w[11:0];
      2'd1: r = w[23:12];
      default: r = w[35:24];
    endcase
    return r;
  endfunction

endpackage

/* src/backface_cull_mesh_compactor.sv */
// Back-face culling and mesh compaction engine.
// Input channel (in_valid_i/in_ready_o) carries one command item: load vertex,
// load pair, load triangle, run cull or read next. Output channel
// (out_valid_o/out_ready_i) returns result items from a single output register.
// A load returns nothing. A read looks up the kept item's index, reads
// its stores and, for a pair or triangle, renumbers one word at a time,
// bounded by the single read port of each store.
// A run makes a flag clearing pass, a triangle pass through one shared
// multiplier, a pair pass, a vertex marking pass and a vertex renumbering
// pass. It answers with a count summary.
// The block takes one item at a time; in_ready_o is high only when idle.
// A new item is taken while an earlier result still waits in the output
// register; a result that meets a full output register waits in place.
// Reset clears the load counts and the read state; the stores hold no data
// until written. While the receiver stalls, the output item holds unchanged.
module backface_cull_mesh_compactor import bfc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         opcode_i,
  input  logic signed [11:0] vert_x_i,
  input  logic signed [11:0] vert_y_i,
  input  logic signed [31:0] vert_z_i,
  input  logic signed [31:0] vert_clip_i,
  input  logic signed [31:0] vert_shade_i,
  input  logic [9:0]         pair_first_i,
  input  logic [9:0]         pair_second_i,
  input  logic [11:0]        edge_zero_i,
  input  logic [11:0]        edge_one_i,
  input  logic [11:0]        edge_two_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         item_kind_o,
  output logic               last_item_o,
  output logic signed [11:0] out_x_o,
  output logic signed [11:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic signed [31:0] out_clip_o,
  output logic signed [31:0] out_shade_o,
  output logic [11:0]        word_first_o,
  output logic [11:0]        word_second_o,
  output logic [11:0]        word_third_o
);

  state_e state_q, state_d;

  logic [P_AW:0]   idx_q, below_q;
  logic [1:0]      k_q;
  logic [V_AW-1:0] vmax_q;
  logic [V_AW:0]   kv_q, ldv_q;
  logic [P_AW:0]   kp_q, ldp_q;
  logic [T_AW:0]   kt_q, ldt_q;
  logic [P_AW+1:0] cursor_q, total;
  logic            valid_q, drop_q;
  logic [1:0]      sec_q;
  logic [35:0]     tri_q, tmp_q;
  logic signed [11:0] vx_q [3];
  logic signed [11:0] vy_q [3];
  logic signed [25:0] p1_q, p2_q;
  logic [11:0]     w_q [3];

  logic               out_valid_q, out_last_q;
  logic [1:0]         out_kind_q;
  logic signed [11:0] out_x_q, out_y_q;
  logic signed [31:0] out_z_q, out_clip_q, out_shade_q;
  logic [11:0]        out_w0_q, out_w1_q, out_w2_q;

  // Stores and derived tables.
  logic [23:0] vxy_mem   [1 << V_AW];
  logic [31:0] vz_mem    [1 << V_AW];
  logic [31:0] vclip_mem [1 << V_AW];
  logic [31:0] vshd_mem  [1 << V_AW];
  logic [19:0] pst_mem   [1 << P_AW];
  logic [35:0] tst_mem   [1 << T_AW];
  logic        ukeep_mem [1 << P_AW];
  logic        udrop_mem [1 << P_AW];
  logic        pdrop_mem [1 << P_AW];
  logic        nkeep_mem [1 << V_AW];
  logic        ndrop_mem [1 << V_AW];
  logic [P_AW-1:0] pni_mem [1 << P_AW];
  logic [V_AW-1:0] vni_mem [1 << V_AW];
  logic [V_AW-1:0] lv_mem  [1 << V_AW];
  logic [P_AW-1:0] lp_mem  [1 << P_AW];
  logic [T_AW-1:0] lt_mem  [1 << T_AW];

  logic [23:0] vxy_rd;
  logic [31:0] vz_rd, vclip_rd, vshd_rd;
  logic [19:0] pst_rd;
  logic [35:0] tst_rd;
  logic        ukeep_rd, udrop_rd, pdrop_rd, nkeep_rd, ndrop_rd;
  logic [P_AW-1:0] pni_rd, lp_rd;
  logic [V_AW-1:0] vni_rd, lv_rd;
  logic [T_AW-1:0] lt_rd;

  logic            accept, out_free, out_load;
  logic            vst_we, pst_we, tst_we;
  logic [V_AW-1:0] vaddr, nf_addr, nf_waddr, vni_raddr;
  logic [P_AW-1:0] paddr, uf_waddr, pni_raddr, lp_raddr;
  logic [T_AW-1:0] taddr, lt_raddr;
  logic            uk_we, ud_we, uf_wd, nk_we, nd_we, nf_wd, pw_we, vw_we, lt_we;
  logic            pdrop_d, rd_ok, cull;
  logic [11:0]     edge_k, edge_r;
  logic [V_AW-1:0] chosen_v, pmax;
  logic signed [11:0] xs, ys;
  logic signed [12:0] dx1, dy1, dx2, dy2, ma, mb;
  logic signed [25:0] mul_p;
  logic signed [26:0] diff;

  logic [1:0]         o_kind;
  logic               o_last;
  logic signed [11:0] o_x, o_y;
  logic signed [31:0] o_z, o_clip, o_shade;
  logic [11:0]        o_w0, o_w1, o_w2;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign total      = (P_AW + 2)'(kv_q) + (P_AW + 2)'(kp_q) + (P_AW + 2)'(kt_q);
  assign rd_ok      = valid_q && (cursor_q < total);
  assign xs = 12'($signed(vert_x_i[COORD_BITS-1:0]));
  assign ys = 12'($signed(vert_y_i[COORD_BITS-1:0]));

  assign edge_k   = edge_sel(tri_q, k_q);
  assign edge_r   = edge_sel(tmp_q, k_q);
  assign chosen_v = edge_k[11] ? pst_rd[19:10] : pst_rd[9:0];
  assign pmax     = (pst_rd[19:10] > pst_rd[9:0]) ? pst_rd[19:10] : pst_rd[9:0];

  assign dx1 = 13'(vx_q[1]) - 13'(vx_q[0]);
  assign dy1 = 13'(vy_q[1]) - 13'(vy_q[0]);
  assign dx2 = 13'(vx_q[2]) - 13'(vx_q[0]);
  assign dy2 = 13'(vy_q[2]) - 13'(vy_q[0]);
  assign ma  = (state_q == S_T_M1) ? dy2 : dx2;
  assign mb  = (state_q == S_T_M1) ? dx1 : dy1;
  assign mul_p = ma * mb;
  assign diff  = 27'(p1_q) - 27'(p2_q);
  // A zero result whose float form would be negative zero counts as back-facing.
  assign cull  = diff[26] || ((p1_q == 26'sd0) && (p2_q == 26'sd0) &&
                 (dy2[12] != dx1[12]) && (dx2[12] == dy1[12]));

  assign pdrop_d = (idx_q < ldp_q) && udrop_rd && !ukeep_rd;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (opcode_i)
            OP_RUN:  state_d = S_CLR;
            OP_READ: state_d = rd_ok ? S_R_L : S_IDLE;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_CLR:   if (idx_q == (P_AW + 1)'((1 << P_AW) - 1)) state_d = S_T_RD;
      S_T_RD:  state_d = (idx_q < (P_AW + 1)'(ldt_q)) ? S_T_E : S_P_RD;
      S_T_E:   state_d = S_T_PA;
      S_T_PA:  state_d = S_T_PB;
      S_T_PB:  state_d = S_T_V;
      S_T_V:   state_d = (k_q == 2'd2) ? S_T_M1 : S_T_PA;
      S_T_M1:  state_d = S_T_M2;
      S_T_M2:  state_d = S_T_CMP;
      S_T_CMP: state_d = S_T_W;
      S_T_W:   if (k_q == 2'd2) state_d = S_T_RD;
      S_P_RD:  state_d = S_P_WR;
      S_P_WR:  state_d = (idx_q == (P_AW + 1)'((1 << P_AW) - 1)) ? S_N_RD : S_P_RD;
      S_N_RD:  state_d = (idx_q < ldp_q) ? S_N_F : S_V_RD;
      S_N_F:   state_d = S_N_S;
      S_N_S:   state_d = S_N_RD;
      S_V_RD:  state_d = S_V_WR;
      S_V_WR:  state_d = (idx_q == (P_AW + 1)'((1 << V_AW) - 1)) ? S_SUM : S_V_RD;
      S_SUM:   if (out_free) state_d = S_IDLE;
      S_R_L:   state_d = S_R_S;
      S_R_S:   state_d = S_R_D;
      S_R_D:   state_d = (sec_q == KIND_VERT) ? S_R_OUT : S_R_N;
      S_R_N:   state_d = S_R_W;
      S_R_W: begin
        if (k_q == ((sec_q == KIND_PAIR) ? 2'd1 : 2'd2)) state_d = S_R_OUT;
        else state_d = S_R_N;
      end
      S_R_OUT: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Memory controls and result fields.
  always_comb begin
    vst_we = accept && (opcode_i == OP_VERT) && !ldv_q[V_AW];
    pst_we = accept && (opcode_i == OP_PAIR) && !ldp_q[P_AW];
    tst_we = accept && (opcode_i == OP_TRI) && !ldt_q[T_AW];
    vaddr  = (state_q == S_T_PB) ? chosen_v : lv_rd;
    paddr  = lp_rd;
    taddr  = lt_rd;
    uk_we = 1'b0; ud_we = 1'b0; uf_wd = 1'b0; uf_waddr = idx_q[P_AW-1:0];
    nk_we = 1'b0; nd_we = 1'b0; nf_wd = 1'b0; nf_waddr = idx_q[V_AW-1:0];
    pw_we = 1'b0; vw_we = 1'b0; lt_we = 1'b0;
    nf_addr   = idx_q[V_AW-1:0];
    vni_raddr = k_q[0] ? tmp_q[19:10] : tmp_q[9:0];
    pni_raddr = edge_r[P_AW-1:0];
    lp_raddr  = P_AW'(cursor_q - (P_AW + 2)'(kv_q));
    lt_raddr  = T_AW'(cursor_q - (P_AW + 2)'(kv_q) - (P_AW + 2)'(kp_q));
    out_load  = 1'b0;
    o_kind = KIND_SUM; o_last = 1'b0; o_x = '0; o_y = '0;
    o_z = '0; o_clip = '0; o_shade = '0; o_w0 = '0; o_w1 = '0; o_w2 = '0;
    case (state_q)
      S_CLR: begin
        uk_we = 1'b1;
        ud_we = 1'b1;
        nk_we = !idx_q[V_AW];
        nd_we = !idx_q[V_AW];
      end
      S_T_RD: taddr = idx_q[T_AW-1:0];
      S_T_PA: paddr = edge_k[P_AW-1:0];
      S_T_CMP: lt_we = !cull;
      S_T_W: begin
        uf_waddr = edge_k[P_AW-1:0];
        uf_wd = 1'b1;
        uk_we = !drop_q;
        ud_we = drop_q;
      end
      S_P_WR: pw_we = 1'b1;
      S_N_RD: paddr = idx_q[P_AW-1:0];
      S_N_F, S_N_S: begin
        paddr    = idx_q[P_AW-1:0];
        nf_waddr = (state_q == S_N_F) ? pst_rd[9:0] : pst_rd[19:10];
        nf_wd    = 1'b1;
        nk_we    = !pdrop_rd;
        nd_we    = pdrop_rd;
      end
      S_V_WR: vw_we = 1'b1;
      S_SUM: begin
        out_load = out_free;
        o_last = (total == '0);
        o_w0 = 12'(kv_q);
        o_w1 = 12'(kp_q);
        o_w2 = 12'(kt_q);
      end
      S_R_OUT: begin
        out_load = out_free;
        o_kind = sec_q;
        o_last = ((cursor_q + 1'b1) == total);
        case (sec_q)
          KIND_VERT: begin
            o_x = vxy_rd[11:0];
            o_y = vxy_rd[23:12];
            o_z = vz_rd;
            o_clip = vclip_rd;
            o_shade = vshd_rd;
          end
          KIND_PAIR: begin
            o_w0 = w_q[0];
            o_w1 = w_q[1];
          end
          default: begin
            o_w0 = w_q[0];
            o_w1 = w_q[1];
            o_w2 = w_q[2];
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (vst_we) begin
      vxy_mem[ldv_q[V_AW-1:0]]   <= {ys, xs};
      vz_mem[ldv_q[V_AW-1:0]]    <= vert_z_i;
      vclip_mem[ldv_q[V_AW-1:0]] <= vert_clip_i;
      vshd_mem[ldv_q[V_AW-1:0]]  <= vert_shade_i;
    end
    vxy_rd   <= vxy_mem[vaddr];
    vz_rd    <= vz_mem[vaddr];
    vclip_rd <= vclip_mem[vaddr];
    vshd_rd  <= vshd_mem[vaddr];
  end

  always_ff @(posedge clk_i) begin
    if (pst_we) pst_mem[ldp_q[P_AW-1:0]] <= {pair_second_i, pair_first_i};
    pst_rd <= pst_mem[paddr];
  end

  always_ff @(posedge clk_i) begin
    if (tst_we) tst_mem[ldt_q[T_AW-1:0]] <= {edge_two_i, edge_one_i, edge_zero_i};
    tst_rd <= tst_mem[taddr];
  end

  always_ff @(posedge clk_i) begin
    if (uk_we) ukeep_mem[uf_waddr] <= uf_wd;
    if (ud_we) udrop_mem[uf_waddr] <= uf_wd;
    ukeep_rd <= ukeep_mem[idx_q[P_AW-1:0]];
    udrop_rd <= udrop_mem[idx_q[P_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (pw_we) begin
      pdrop_mem[idx_q[P_AW-1:0]] <= pdrop_d;
      pni_mem[idx_q[P_AW-1:0]]   <= P_AW'(idx_q - below_q);
    end
    pdrop_rd <= pdrop_mem[idx_q[P_AW-1:0]];
    pni_rd   <= pni_mem[pni_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (nk_we) nkeep_mem[nf_waddr] <= nf_wd;
    if (nd_we) ndrop_mem[nf_waddr] <= nf_wd;
    nkeep_rd <= nkeep_mem[nf_addr];
    ndrop_rd <= ndrop_mem[nf_addr];
  end

  always_ff @(posedge clk_i) begin
    if (vw_we) vni_mem[idx_q[V_AW-1:0]] <= V_AW'(idx_q - below_q);
    vni_rd <= vni_mem[vni_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (vw_we && (idx_q[V_AW-1:0] <= vmax_q) && !(ndrop_rd && !nkeep_rd)) begin
      lv_mem[kv_q[V_AW-1:0]] <= idx_q[V_AW-1:0];
    end
    lv_rd <= lv_mem[cursor_q[V_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (pw_we && !pdrop_d && (idx_q < ldp_q)) lp_mem[kp_q[P_AW-1:0]] <= idx_q[P_AW-1:0];
    lp_rd <= lp_mem[lp_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (lt_we) lt_mem[kt_q[T_AW-1:0]] <= idx_q[T_AW-1:0];
    lt_rd <= lt_mem[lt_raddr];
  end

  // Sequencer state and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      below_q  <= '0;
      k_q      <= '0;
      vmax_q   <= '0;
      kv_q     <= '0;
      kp_q     <= '0;
      kt_q     <= '0;
      ldv_q    <= '0;
      ldp_q    <= '0;
      ldt_q    <= '0;
      cursor_q <= '0;
      valid_q  <= 1'b0;
      sec_q    <= KIND_VERT;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (opcode_i)
              OP_VERT: begin
                if (!ldv_q[V_AW]) ldv_q <= ldv_q + 1'b1;
                valid_q <= 1'b0;
              end
              OP_PAIR: begin
                if (!ldp_q[P_AW]) ldp_q <= ldp_q + 1'b1;
                valid_q <= 1'b0;
              end
              OP_TRI: begin
                if (!ldt_q[T_AW]) ldt_q <= ldt_q + 1'b1;
                valid_q <= 1'b0;
              end
              OP_RUN: begin
                idx_q   <= '0;
                valid_q <= 1'b0;
              end
              OP_READ: begin
                if (cursor_q < (P_AW + 2)'(kv_q)) sec_q <= KIND_VERT;
                else if (cursor_q < (P_AW + 2)'(kv_q) + (P_AW + 2)'(kp_q)) sec_q <= KIND_PAIR;
                else sec_q <= KIND_TRI;
              end
              default: ;
            endcase
          end
        end
        S_CLR: begin
          idx_q  <= (state_d == S_T_RD) ? '0 : idx_q + 1'b1;
          vmax_q <= '0;
          kt_q   <= '0;
        end
        S_T_RD: begin
          if (state_d == S_P_RD) begin
            idx_q   <= '0;
            below_q <= '0;
            kp_q    <= '0;
          end
        end
        S_T_E: k_q <= '0;
        S_T_PB: if (pmax > vmax_q) vmax_q <= pmax;
        S_T_V: if (k_q != 2'd2) k_q <= k_q + 1'b1;
        S_T_M1: p1_q <= mul_p;
        S_T_M2: p2_q <= mul_p;
        S_T_CMP: begin
          k_q <= '0;
          if (!cull) kt_q <= kt_q + 1'b1;
        end
        S_T_W: begin
          if (k_q == 2'd2) idx_q <= idx_q + 1'b1;
          else k_q <= k_q + 1'b1;
        end
        S_P_WR: begin
          if (pdrop_d) below_q <= below_q + 1'b1;
          else if (idx_q < ldp_q) kp_q <= kp_q + 1'b1;
          idx_q <= (state_d == S_N_RD) ? '0 : idx_q + 1'b1;
        end
        S_N_RD: begin
          if (state_d == S_V_RD) begin
            idx_q   <= '0;
            below_q <= '0;
            kv_q    <= '0;
          end
        end
        S_N_S: idx_q <= idx_q + 1'b1;
        S_V_WR: begin
          if (idx_q[V_AW-1:0] <= vmax_q) begin
            if (ndrop_rd && !nkeep_rd) below_q <= below_q + 1'b1;
            else kv_q <= kv_q + 1'b1;
          end
          idx_q <= idx_q + 1'b1;
        end
        S_SUM: begin
          if (out_free) begin
            valid_q  <= 1'b1;
            cursor_q <= '0;
          end
        end
        S_R_D: k_q <= '0;
        S_R_W: if (state_d == S_R_N) k_q <= k_q + 1'b1;
        S_R_OUT: if (out_free) cursor_q <= cursor_q + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_T_E: tri_q <= tst_rd;
      S_T_V: begin
        vx_q[k_q] <= vxy_rd[11:0];
        vy_q[k_q] <= vxy_rd[23:12];
      end
      S_T_CMP: drop_q <= cull;
      S_R_D: tmp_q <= (sec_q == KIND_PAIR) ? {16'd0, pst_rd} : tst_rd;
      S_R_W: begin
        if (sec_q == KIND_PAIR) w_q[k_q] <= {2'd0, vni_rd};
        else w_q[k_q] <= {edge_r[11], pni_rd};
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q  <= o_kind;
      out_last_q  <= o_last;
      out_x_q     <= o_x;
      out_y_q     <= o_y;
      out_z_q     <= o_z;
      out_clip_q  <= o_clip;
      out_shade_q <= o_shade;
      out_w0_q    <= o_w0;
      out_w1_q    <= o_w1;
      out_w2_q    <= o_w2;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign item_kind_o   = out_kind_q;
  assign last_item_o   = out_last_q;
  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign out_z_o       = out_z_q;
  assign out_clip_o    = out_clip_q;
  assign out_shade_o   = out_shade_q;
  assign word_first_o  = out_w0_q;
  assign word_second_o = out_w1_q;
  assign word_third_o  = out_w2_q;

`ifndef SYNTHESIS
  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (cursor_q <= total)) else $error("read cursor beyond kept items");
  a_load_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ldv_q <= (V_AW + 1)'(1 << V_AW)) && (ldt_q <= (T_AW + 1)'(1 << T_AW)))
    else $error("load count beyond store size");
  a_edge_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_T_W) |-> (k_q != 2'd3)) else $error("edge step out of range");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !out_load) else $error("result overwritten");
`endif

endmodule
